[rtl/ssr_pkg.sv]
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants of the streaming substring replacer
// Item layouts of the text channels, register indexes and fixed sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

  localparam int ByteW          = 8;
  localparam int LenW           = 4;
  localparam int CfgDataW       = 64;
  localparam int CfgIdxW        = 2;
  localparam int MaxPatternDef  = 8;
  localparam int MaxReplacement = 8;
  // A burst holds either a whole replacement or a flushed window.
  localparam int BurstDepth     = 8;
  localparam int CntW           = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgPatternBytes     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternLength    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgReplacementBytes = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgReplacementLength = 2'd3;

  typedef struct packed {
    logic             end_of_text;
    logic             has_byte;
    logic [ByteW-1:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic             text_done;
    logic             last_of_run;
    logic             out_valid;
    logic [ByteW-1:0] out_byte;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/ssr_stream_if.sv]
// ----------------------------------------------------------------------------
// ssr_stream_if: valid/ready channel for one word of a given item type
// The source drives valid and data, the sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssr_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/streaming_substring_replace.sv]
// ----------------------------------------------------------------------------
// streaming_substring_replace: byte stream find and replace
// Replaces each leftmost, non-overlapping occurrence of a pattern of up to
// MaxPattern bytes by a replacement of up to eight bytes, one byte per word.
// ----------------------------------------------------------------------------
//  channel     | dir | word                                        | accepted when
//  text_in_i   | in  | text_byte, has_byte, end_of_text            | valid & ready
//  text_out_o  | out | out_byte, out_valid, last_of_run, text_done | valid & ready
//  cfg_*       | in  | register index and 64-bit data              | cfg_we_i
//
//  Text flows at a byte per cycle while the output is ready and each input
//  word yields at most one output word. A word that yields more holds the input
//  while the burst register drains through the output register, one word per
//  cycle unless stalled. Reset loads the register defaults and empties the
//  window; no clearing pass. Output stalls fill the burst register first.
// ----------------------------------------------------------------------------
`default_nettype none

module streaming_substring_replace #(
  parameter int MaxPattern = ssr_pkg::MaxPatternDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ssr_stream_if.sink                         text_in_i,
  ssr_stream_if.source                       text_out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [ssr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ssr_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int FillW = $clog2(MaxPattern + 1);
  localparam int ByteW = ssr_pkg::ByteW;
  localparam int LenW  = ssr_pkg::LenW;
  localparam int CntW  = ssr_pkg::CntW;
  localparam int Depth = ssr_pkg::BurstDepth;

  // Configuration registers.
  logic [ssr_pkg::CfgDataW-1:0] pat_bytes_q, rep_bytes_q;
  logic [LenW-1:0]              pat_len_q, rep_len_q;

  // Match window.
  logic [ByteW-1:0] win_q [MaxPattern];
  logic [ByteW-1:0] win_d [MaxPattern];
  logic [FillW-1:0] fill_q, fill_d;

  // Burst register and output register.
  logic [ByteW-1:0]   bbyte_q [Depth];
  logic [ByteW-1:0]   bbyte_d [Depth];
  logic [CntW-1:0]    bcnt_q, bcnt_d;
  logic               beot_q, beot_d;
  logic               bvld_q, bvld_d;
  logic               ov_q, ov_d;
  ssr_pkg::out_item_t out_q, out_d;

  logic             in_rdy, acc;
  logic [ByteW-1:0] in_b;
  logic             has, eot;
  logic [FillW-1:0] plen, af;
  logic [CntW-1:0]  rlen, n, lcnt;
  logic             full, hit, miss, lvld;
  logic [ByteW-1:0] aw [MaxPattern];
  logic [ByteW-1:0] aw_ext [Depth];
  logic [ByteW-1:0] lst [Depth];

  logic [ByteW-1:0] sb [Depth];
  logic [CntW-1:0]  sc;
  logic             se, sv, out_free;

  assign in_b = text_in_i.data.text_byte;
  assign has  = text_in_i.data.has_byte;
  assign eot  = text_in_i.data.end_of_text;

  // The input waits while any word is still held in the burst register.
  assign in_rdy          = (bcnt_q == '0);
  assign text_in_i.ready = in_rdy;
  assign acc             = text_in_i.valid && in_rdy;

  // Lengths as the datapath uses them: zero pattern length acts as one.
  always_comb begin
    if (pat_len_q == '0) begin
      plen = FillW'(1);
    end else if (pat_len_q > LenW'(MaxPattern)) begin
      plen = FillW'(MaxPattern);
    end else begin
      plen = FillW'(pat_len_q);
    end
    if (rep_len_q > LenW'(ssr_pkg::MaxReplacement)) begin
      rlen = CntW'(ssr_pkg::MaxReplacement);
    end else begin
      rlen = CntW'(rep_len_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= LenW'(1);
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssr_pkg::CfgPatternBytes: pat_bytes_q <= cfg_data_i;
        ssr_pkg::CfgPatternLength: begin
          // The window must never hold more bytes than the pattern length.
          if (fill_q == '0) pat_len_q <= cfg_data_i[LenW-1:0];
        end
        ssr_pkg::CfgReplacementBytes: rep_bytes_q <= cfg_data_i;
        ssr_pkg::CfgReplacementLength: rep_len_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Window with the new byte appended, match test and the result list.
  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      aw[i] = (has && fill_q == FillW'(i)) ? in_b : win_q[i];
    end
    for (int i = 0; i < Depth; i++) begin
      aw_ext[i] = '0;
    end
    for (int i = 0; i < MaxPattern; i++) begin
      aw_ext[i] = aw[i];
    end

    af   = has ? fill_q + FillW'(1) : fill_q;
    full = has && (fill_q + FillW'(1) == plen);
    hit  = full;
    for (int i = 0; i < MaxPattern; i++) begin
      if (FillW'(i) < plen && aw[i] != pat_bytes_q[ByteW*i +: ByteW]) hit = 1'b0;
    end
    miss = full && !hit;

    // Every list is either the replacement or a prefix of the window.
    if (hit) begin
      n = rlen;
    end else if (miss) begin
      n = eot ? CntW'(plen) : CntW'(1);
    end else begin
      n = eot ? CntW'(af) : '0;
    end

    for (int i = 0; i < Depth; i++) begin
      if (n == '0) begin
        lst[i] = '0;
      end else if (hit) begin
        lst[i] = rep_bytes_q[ByteW*i +: ByteW];
      end else begin
        lst[i] = aw_ext[i];
      end
    end
    // An end of text that yields no byte still sends a bare end marker.
    lcnt = (eot && n == '0) ? CntW'(1) : n;
    lvld = (n != '0);

    win_d  = aw;
    fill_d = af;
    if (eot || hit) begin
      fill_d = '0;
    end else if (miss) begin
      fill_d = plen - FillW'(1);
      for (int i = 0; i < MaxPattern - 1; i++) begin
        win_d[i] = aw[i+1];
      end
    end
  end

  // The first word of a fresh list goes straight to the output register when
  // it is free; the rest waits in the burst register.
  always_comb begin
    sb = acc ? lst  : bbyte_q;
    sc = acc ? lcnt : bcnt_q;
    se = acc ? eot  : beot_q;
    sv = acc ? lvld : bvld_q;

    bbyte_d  = sb;
    bcnt_d   = sc;
    beot_d   = se;
    bvld_d   = sv;
    ov_d     = ov_q;
    out_d    = out_q;
    out_free = !ov_q || text_out_o.ready;

    if (out_free) begin
      ov_d = 1'b0;
      if (sc != '0) begin
        ov_d              = 1'b1;
        out_d.out_byte    = sb[0];
        out_d.out_valid   = sv;
        out_d.last_of_run = (sc == CntW'(1));
        out_d.text_done   = (sc == CntW'(1)) && se;
        for (int i = 0; i < Depth - 1; i++) begin
          bbyte_d[i] = sb[i+1];
        end
        bbyte_d[Depth-1] = '0;
        bcnt_d = sc - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bcnt_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (acc) fill_q <= fill_d;
      bcnt_q <= bcnt_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) win_q <= win_d;
    bbyte_q <= bbyte_d;
    beot_q  <= beot_d;
    bvld_q  <= bvld_d;
    out_q   <= out_d;
  end

  assign text_out_o.valid = ov_q;
  assign text_out_o.data  = out_q;

endmodule

`default_nettype wire

[rtl/ssr_checker.sv]
// ----------------------------------------------------------------------------
// ssr_checker: port-level checks of the streaming substring replacer
// Watches both text channels and is bound to every top-level instance.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               in_eot_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire ssr_pkg::out_item_t out_item_i
);

  // A stalled output word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("output word changed while stalled");

  // The end of the text is always the last word of its input word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.text_done |-> out_item_i.last_of_run)
    else $error("text_done without last_of_run");

  // A bare end marker carries a zero byte and closes the text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.out_valid |->
      out_item_i.out_byte == '0 && out_item_i.text_done)
    else $error("malformed bare end marker");

  // An end of text always yields a word, so under a stall it must be buffered
  // and hold off the next input word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_eot_i && out_valid_i && !out_ready_i
      |=> !in_ready_i)
    else $error("input taken while a stalled end of text is buffered");

endmodule

bind streaming_substring_replace ssr_checker u_ssr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (text_in_i.valid),
  .in_ready_i  (text_in_i.ready),
  .in_eot_i    (text_in_i.data.end_of_text),
  .out_valid_i (text_out_o.valid),
  .out_ready_i (text_out_o.ready),
  .out_item_i  (text_out_o.data)
);

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the streaming substring replacer
// Streams texts through the block with random gaps on the input and random
// stalls on the output, predicts every output word from its own model of the
// match window, and compares each word field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SettleCycles = 16;   // covers the longest burst plus the output register
  localparam int QuietLimit   = 2000;
  localparam int RandomItems  = 380;

  logic                         clk_i     = 1'b0;
  logic                         rst_ni    = 1'b0;
  logic                         cfg_we    = 1'b0;
  logic [ssr_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [ssr_pkg::CfgDataW-1:0] cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  ssr_pkg::in_item_t            in_word   = '0;
  logic                         out_ready = 1'b0;

  ssr_stream_if #(.item_t(ssr_pkg::in_item_t))  text_in  ();
  ssr_stream_if #(.item_t(ssr_pkg::out_item_t)) text_out ();

  assign text_in.valid  = in_valid;
  assign text_in.data   = in_word;
  assign text_out.ready = out_ready;

  streaming_substring_replace u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .text_in_i  (text_in),
    .text_out_o (text_out),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: register copies and the match window.
  logic [ssr_pkg::CfgDataW-1:0] pattern_reg     = '0;
  logic [ssr_pkg::LenW-1:0]     pattern_len_reg = ssr_pkg::LenW'(1);
  logic [ssr_pkg::CfgDataW-1:0] repl_reg        = '0;
  logic [ssr_pkg::LenW-1:0]     repl_len_reg    = '0;
  logic [ssr_pkg::ByteW-1:0]    text_window [ssr_pkg::MaxPatternDef];
  int                           window_count    = 0;

  ssr_pkg::in_item_t  pending_words[$];
  ssr_pkg::out_item_t expected_words[$];
  int        items_queued = 0;
  int        items_taken  = 0;
  int        errors       = 0;
  int        quiet_cycles = 0;
  logic      in_fed       = 1'b0;
  logic      out_fed      = 1'b0;
  int        feed_gap     = 0;
  int        drain_stall  = 0;
  bit        feed_calm    = 1'b0;
  bit        drain_calm   = 1'b0;

  function automatic int pattern_len_eff();
    if (pattern_len_reg == 0) return 1;
    if (pattern_len_reg > ssr_pkg::MaxPatternDef) return ssr_pkg::MaxPatternDef;
    return int'(pattern_len_reg);
  endfunction

  // Appends the output words that one accepted input word causes.
  function automatic void predict_words(ssr_pkg::in_item_t w);
    logic [ssr_pkg::ByteW-1:0] burst_byte [ssr_pkg::BurstDepth+1];
    logic                      burst_valid [ssr_pkg::BurstDepth+1];
    int                        n;
    int                        plen;
    int                        rlen;
    int                        i;
    bit                        hit;
    ssr_pkg::out_item_t        o;
    n    = 0;
    plen = pattern_len_eff();
    rlen = (repl_len_reg > ssr_pkg::MaxReplacement) ? ssr_pkg::MaxReplacement
                                                     : int'(repl_len_reg);
    if (w.has_byte) begin
      if (window_count < plen) begin
        text_window[window_count] = w.text_byte;
        window_count++;
      end
      if (window_count >= plen) begin
        hit = 1'b1;
        for (i = 0; i < plen; i++) begin
          if (text_window[i] != pattern_reg[ssr_pkg::ByteW*i +: ssr_pkg::ByteW]) hit = 1'b0;
        end
        if (hit) begin
          for (i = 0; i < rlen; i++) begin
            burst_byte[n]  = repl_reg[ssr_pkg::ByteW*i +: ssr_pkg::ByteW];
            burst_valid[n] = 1'b1;
            n++;
          end
          window_count = 0;
        end else begin
          burst_byte[n]  = text_window[0];
          burst_valid[n] = 1'b1;
          n++;
          for (i = 1; i < window_count; i++) text_window[i-1] = text_window[i];
          window_count--;
        end
      end
    end
    if (w.end_of_text) begin
      for (i = 0; i < window_count; i++) begin
        burst_byte[n]  = text_window[i];
        burst_valid[n] = 1'b1;
        n++;
      end
      window_count = 0;
      if (n == 0) begin
        burst_byte[0]  = '0;
        burst_valid[0] = 1'b0;
        n = 1;
      end
    end
    for (i = 0; i < n; i++) begin
      o.out_byte    = burst_byte[i];
      o.out_valid   = burst_valid[i];
      o.last_of_run = (i == n - 1);
      o.text_done   = w.end_of_text && (i == n - 1);
      expected_words.push_back(o);
    end
  endfunction

  function automatic void report_mismatch(string field, logic [ssr_pkg::ByteW-1:0] want,
                                          logic [ssr_pkg::ByteW-1:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    errors++;
  endfunction

  function automatic ssr_pkg::in_item_t make_word(logic [ssr_pkg::ByteW-1:0] b,
                                                  logic has, logic eot);
    ssr_pkg::in_item_t w;
    w.text_byte   = b;
    w.has_byte    = has;
    w.end_of_text = eot;
    return w;
  endfunction

  always @(posedge clk_i) begin : monitor
    ssr_pkg::out_item_t want;
    ssr_pkg::out_item_t got;
    if (rst_ni) begin
      in_fed  <= text_in.valid && text_in.ready;
      out_fed <= text_out.valid && text_out.ready;
      if (text_in.valid && text_in.ready) begin
        predict_words(text_in.data);
        items_taken++;
      end
      if (text_out.valid && text_out.ready) begin
        got = text_out.data;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected output word, expected none, actual %0h", $time, got);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", want.out_byte, got.out_byte);
          if (got.out_valid !== want.out_valid)
            report_mismatch("out_valid", want.out_valid, got.out_valid);
          if (got.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", want.last_of_run, got.last_of_run);
          if (got.text_done !== want.text_done)
            report_mismatch("text_done", want.text_done, got.text_done);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((text_in.valid && text_in.ready) || (text_out.valid && text_out.ready) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // A word stays offered until it is taken; the gap drawn with it applies after.
  always @(negedge clk_i) begin : feeder
    if (rst_ni && !(in_valid && !in_fed)) begin
      if (feed_gap > 0) begin
        in_valid <= 1'b0;
        feed_gap--;
      end else if (pending_words.size() > 0) begin
        in_word  <= pending_words.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) feed_calm = !feed_calm;
        feed_gap = feed_calm ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : drain
    if (rst_ni && !(out_ready && !out_fed)) begin
      if (drain_stall > 0) begin
        out_ready <= 1'b0;
        drain_stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 39) == 0) drain_calm = !drain_calm;
        drain_stall = drain_calm ? 0 : $urandom_range(0, 8);
      end
    end
  end

  task automatic enqueue(ssr_pkg::in_item_t w);
    pending_words.push_back(w);
    items_queued++;
  endtask

  // Waits until every word is taken and answered, then lets the block drain.
  task automatic settle();
    while (items_taken != items_queued || expected_words.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [ssr_pkg::CfgIdxW-1:0] idx,
                           logic [ssr_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      ssr_pkg::CfgPatternBytes:      pattern_reg = data;
      ssr_pkg::CfgPatternLength: begin
        if (window_count == 0) pattern_len_reg = data[ssr_pkg::LenW-1:0];
      end
      ssr_pkg::CfgReplacementBytes:  repl_reg = data;
      ssr_pkg::CfgReplacementLength: repl_len_reg = data[ssr_pkg::LenW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    ssr_pkg::in_item_t            txt[$];
    ssr_pkg::in_item_t            last;
    logic [ssr_pkg::CfgDataW-1:0] pat;
    logic [ssr_pkg::ByteW-1:0]    base;
    logic [ssr_pkg::ByteW-1:0]    b;
    int                           random_count;
    int                           plen;
    int                           pick;
    int                           split;
    int                           r;
    int                           i;
    int                           j;
    random_count = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings delete every zero byte.
    enqueue(make_word(8'h00, 1'b1, 1'b0));
    enqueue(make_word(8'hFF, 1'b1, 1'b1));

    // Three-byte pattern, two-byte replacement, then a word that carries
    // nothing and a bare end marker on an empty window.
    settle();
    write_reg(ssr_pkg::CfgPatternBytes, 64'h0000_0000_0063_6261);
    write_reg(ssr_pkg::CfgPatternLength, 64'd3);
    write_reg(ssr_pkg::CfgReplacementBytes, 64'h0000_0000_0000_5958);
    write_reg(ssr_pkg::CfgReplacementLength, 64'd2);
    enqueue(make_word(8'h61, 1'b1, 1'b0));
    enqueue(make_word(8'h62, 1'b1, 1'b0));
    enqueue(make_word(8'h63, 1'b1, 1'b0));
    enqueue(make_word(8'h61, 1'b1, 1'b0));
    enqueue(make_word(8'h62, 1'b1, 1'b0));
    enqueue(make_word(8'h64, 1'b1, 1'b1));
    enqueue(make_word(8'h5A, 1'b0, 1'b0));
    enqueue(make_word(8'hC3, 1'b0, 1'b1));

    // A pattern length write while the window holds a byte must be ignored;
    // the end of text without a byte then flushes the window.
    enqueue(make_word(8'h61, 1'b1, 1'b0));
    settle();
    write_reg(ssr_pkg::CfgPatternLength, 64'd0);
    enqueue(make_word(8'h62, 1'b1, 1'b0));
    enqueue(make_word(8'h3C, 1'b0, 1'b1));

    // Length zero acts as one; an oversized replacement length saturates.
    settle();
    write_reg(ssr_pkg::CfgPatternLength, 64'd0);
    write_reg(ssr_pkg::CfgPatternBytes, 64'h0000_0000_0000_00FF);
    write_reg(ssr_pkg::CfgReplacementBytes, 64'hA55A_0FF0_3CC3_9669);
    write_reg(ssr_pkg::CfgReplacementLength, 64'd15);
    enqueue(make_word(8'hFF, 1'b1, 1'b1));

    // Oversized pattern length saturates to eight; the deleted match leaves
    // only the bare end marker.
    settle();
    write_reg(ssr_pkg::CfgPatternBytes, '1);
    write_reg(ssr_pkg::CfgPatternLength, 64'd15);
    write_reg(ssr_pkg::CfgReplacementLength, 64'd0);
    for (i = 0; i < 8; i++) enqueue(make_word(8'hFF, 1'b1, i == 7));

    while (random_count < RandomItems) begin
      settle();
      base = ssr_pkg::ByteW'($urandom_range(0, 255));
      pat  = {$urandom, $urandom};
      for (j = 0; j < 8; j++) begin
        pat[ssr_pkg::ByteW*j +: ssr_pkg::ByteW] = base ^ ssr_pkg::ByteW'($urandom_range(0, 3));
      end
      r = $urandom_range(0, 9);
      if (r == 0)      j = 0;
      else if (r == 1) j = $urandom_range(9, 15);
      else if (r < 7)  j = $urandom_range(1, 3);
      else             j = $urandom_range(4, 8);
      write_reg(ssr_pkg::CfgPatternBytes, pat);
      write_reg(ssr_pkg::CfgPatternLength, ssr_pkg::CfgDataW'(j));
      write_reg(ssr_pkg::CfgReplacementBytes, {$urandom, $urandom});
      j = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      write_reg(ssr_pkg::CfgReplacementLength, ssr_pkg::CfgDataW'(j));

      // Texts mix whole or nearly whole pattern copies with single pattern bytes
      // and random words, so that matches, near misses and overlaps are frequent.
      txt.delete();
      plen = pattern_len_eff();
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
          for (i = 0; i < plen; i++) begin
            b = pattern_reg[ssr_pkg::ByteW*i +: ssr_pkg::ByteW];
            if (pick == 3 && i == plen - 1) begin
              b = b ^ ssr_pkg::ByteW'(1 << $urandom_range(0, 7));
            end
            txt.push_back(make_word(b, 1'b1, 1'b0));
          end
        end else if (pick <= 7) begin
          j = $urandom_range(0, plen - 1);
          txt.push_back(make_word(pattern_reg[ssr_pkg::ByteW*j +: ssr_pkg::ByteW],
                                  1'b1, 1'b0));
        end else begin
          txt.push_back(make_word(ssr_pkg::ByteW'($urandom_range(0, 255)), pick == 8, 1'b0));
        end
      end
      last = txt.pop_back();
      if (last.has_byte && $urandom_range(0, 1) == 1) begin
        last.end_of_text = 1'b1;
        txt.push_back(last);
      end else begin
        txt.push_back(last);
        txt.push_back(make_word(ssr_pkg::ByteW'($urandom_range(0, 255)), 1'b0, 1'b1));
      end

      split = txt.size();
      if ($urandom_range(0, 4) == 0) split = $urandom_range(1, txt.size() - 1);
      for (i = 0; i < txt.size(); i++) begin
        if (i == split) begin
          settle();
          write_reg(ssr_pkg::CfgPatternLength, ssr_pkg::CfgDataW'($urandom_range(0, 15)));
        end
        if (txt[i].has_byte || txt[i].end_of_text) random_count++;
        enqueue(txt[i]);
      end
    end

    settle();
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ssr_pkg.sv
rtl/ssr_stream_if.sv
rtl/streaming_substring_replace.sv
rtl/ssr_checker.sv
dv/tb_top.sv
